// ----- design/cll_pkg.sv -----
// cll_pkg: shared types and constants for the corner line least-squares block.
// Used by the channel interfaces, the shared multiply/divide unit and the top level.
// No dependencies.
package cll_pkg;

	localparam int MAX_RECTS  = 64;
	localparam int COORD_BITS = 12;

	// input field widths
	localparam int SIZE_BITS = COORD_BITS + 1;
	// corner coordinate, signed: -1 .. 2^COORD_BITS - 1 + 2^SIZE_BITS - 2
	localparam int PT_W  = COORD_BITS + 3;
	localparam int CNT_W = $clog2(MAX_RECTS + 1);
	localparam int SUM_W = PT_W + CNT_W;
	localparam int SQ_W  = 2 * PT_W + CNT_W;

	// shared unit datapath
	localparam int DW     = 64;
	localparam int ITER_W = $clog2(DW);
	localparam int FRAC_W = 16;
	localparam int OUT_W  = 32;

	typedef enum logic {
		OP_MUL,
		OP_DIV
	} op_t;

	typedef struct packed {
		logic start;
		op_t  op;
	} unit_cmd_t;

	typedef struct packed {
		logic busy;
		logic done;
	} unit_sts_t;

	typedef enum logic [1:0] {
		S_IDLE,
		S_RUN,
		S_OUT
	} state_t;

	typedef enum logic [3:0] {
		A_XY,   // accumulate x*y
		A_XX,   // accumulate x*x, x, y
		F_NXY,  // n * Sxy
		F_SXY,  // Sx * Sy, numerator
		F_NXX,  // n * Sxx
		F_SXX,  // Sx * Sx, denominator
		F_SDIV, // slope division
		F_SMUL, // slope * Sx
		F_IDIV  // intercept division
	} step_t;

endpackage

// ----- design/cll_if.sv -----
// cll_if: valid/ready channel interfaces for rectangle beats and fit result beats.
// Depends on cll_pkg for field widths.
interface rect_if;
	logic                            valid;
	logic                            ready;
	logic [cll_pkg::COORD_BITS-1:0]  rect_left;
	logic [cll_pkg::COORD_BITS-1:0]  rect_top;
	logic [cll_pkg::SIZE_BITS-1:0]   rect_width;
	logic [cll_pkg::SIZE_BITS-1:0]   rect_height;
	logic                            last_rect;

	modport source(output valid, rect_left, rect_top, rect_width, rect_height, last_rect,
		input ready);
	modport sink(input valid, rect_left, rect_top, rect_width, rect_height, last_rect,
		output ready);
endinterface

interface fit_if;
	logic                             valid;
	logic                             ready;
	logic signed [cll_pkg::OUT_W-1:0] slope_top;
	logic signed [cll_pkg::OUT_W-1:0] intercept_top;
	logic signed [cll_pkg::OUT_W-1:0] slope_bottom;
	logic signed [cll_pkg::OUT_W-1:0] intercept_bottom;
	logic                             top_degenerate;
	logic                             bottom_degenerate;

	modport source(output valid, slope_top, intercept_top, slope_bottom, intercept_bottom,
		top_degenerate, bottom_degenerate, input ready);
	modport sink(input valid, slope_top, intercept_top, slope_bottom, intercept_bottom,
		top_degenerate, bottom_degenerate, output ready);
endinterface

// ----- design/cll_mul_div.sv -----
// cll_mul_div: shared bit-serial unit, 64-bit shift-add multiply (low product)
// or 64-bit unsigned restoring divide (quotient). Depends on cll_pkg.
module cll_mul_div (
	input  logic                    clk,
	input  logic                    arst_n,
	input  cll_pkg::unit_cmd_t      cmd,
	input  logic [cll_pkg::DW-1:0]  a,
	input  logic [cll_pkg::DW-1:0]  b,
	output cll_pkg::unit_sts_t      sts,
	output logic [cll_pkg::DW-1:0]  res
);

	logic                        busy_q;
	logic                        done_q;
	logic [cll_pkg::ITER_W-1:0]  cnt_q;
	cll_pkg::op_t                op_q;
	logic [cll_pkg::DW-1:0]      a_q;
	logic [cll_pkg::DW-1:0]      b_q;
	logic [cll_pkg::DW-1:0]      acc_q;
	logic [cll_pkg::DW:0]        rem_q;
	logic [cll_pkg::DW:0]        rem_sh;
	logic                        fits;

	// divide step: shift in next dividend bit, trial subtract
	assign rem_sh = {rem_q[cll_pkg::DW-1:0], a_q[cll_pkg::DW-1]};
	assign fits   = rem_sh >= {1'b0, b_q};

	// control
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			busy_q <= 1'b0;
			done_q <= 1'b0;
			cnt_q  <= '0;
		end else begin
			done_q <= 1'b0;
			if (cmd.start) begin
				busy_q <= 1'b1;
				cnt_q  <= '0;
			end else if (busy_q) begin
				cnt_q <= cnt_q + 1'b1;
				if (cnt_q == '1) begin
					busy_q <= 1'b0;
					done_q <= 1'b1;
				end
			end
		end
	end

	// datapath
	always_ff @(posedge clk) begin
		if (cmd.start) begin
			op_q  <= cmd.op;
			a_q   <= a;
			b_q   <= b;
			acc_q <= '0;
			rem_q <= '0;
		end else if (busy_q) begin
			if (op_q == cll_pkg::OP_MUL) begin
				if (b_q[0])
					acc_q <= acc_q + a_q;
				a_q <= a_q << 1;
				b_q <= b_q >> 1;
			end else begin
				if (fits) begin
					rem_q <= rem_sh - {1'b0, b_q};
					a_q   <= {a_q[cll_pkg::DW-2:0], 1'b1};
				end else begin
					rem_q <= rem_sh;
					a_q   <= {a_q[cll_pkg::DW-2:0], 1'b0};
				end
			end
		end
	end

	assign sts.busy = busy_q;
	assign sts.done = done_q;
	assign res      = (op_q == cll_pkg::OP_MUL) ? acc_q : a_q;

endmodule

// ----- design/corner_line_least_squares.sv -----
// corner_line_least_squares: top level, sequencer, accumulators and fit result register.
// Depends on cll_pkg, cll_if (rect_if, fit_if) and cll_mul_div.
//
// Takes one rectangle beat at a time and sums count, x, y, x*y and x*x for the top-left
// and bottom-right corners (at most MAX_RECTS rectangles per run; later ones are dropped
// but their last flag still counts). On the beat flagged last it fits y = b + m*x to each
// corner set and emits one result beat in signed Q16.16, rounded to nearest (ties away
// from zero) and saturated; a zero denominator gives the degenerate flag with m = b = 0.
// All multiplies and divides run through one bit-serial 64-bit multiply/divide unit,
// one bit per cycle. A rectangle takes four operations, during which rect.ready is low;
// the fit adds up to fourteen operations, plus a wait for the output register to be
// free. A result beat waits in its own register, so the next run's rectangles are taken
// while it is pending.
module corner_line_least_squares (
	input  logic     clk,
	input  logic     arst_n,
	rect_if.sink     rect,
	fit_if.source    fit
);

	// control
	cll_pkg::state_t    state_q, state_d;
	cll_pkg::step_t     step_q, step_d;
	logic               set_q, set_d;
	logic               pend_q;
	cll_pkg::unit_cmd_t cmd;
	cll_pkg::unit_sts_t sts;
	logic               unit_start;
	cll_pkg::op_t       unit_op;
	logic               rect_acc;
	logic               out_load;

	// latched beat
	logic signed [cll_pkg::PT_W-1:0] pt_x_q [2];
	logic signed [cll_pkg::PT_W-1:0] pt_y_q [2];
	logic                            last_q;

	// accumulators, index 0 top-left, 1 bottom-right
	logic        [cll_pkg::CNT_W-1:0] count_q;
	logic signed [cll_pkg::SUM_W-1:0] sx_q  [2];
	logic signed [cll_pkg::SUM_W-1:0] sy_q  [2];
	logic signed [cll_pkg::SQ_W-1:0]  sxy_q [2];
	logic signed [cll_pkg::SQ_W-1:0]  sxx_q [2];

	// fit temporaries and per-set results
	logic signed [cll_pkg::DW-1:0]    t_q, num_q, den_q;
	logic signed [cll_pkg::OUT_W-1:0] slope_q [2];
	logic signed [cll_pkg::OUT_W-1:0] icpt_q  [2];
	logic                             degen_q [2];

	// output register
	logic                             out_valid_q;
	logic signed [cll_pkg::OUT_W-1:0] o_slope_q [2];
	logic signed [cll_pkg::OUT_W-1:0] o_icpt_q  [2];
	logic                             o_degen_q [2];

	// unit operands
	logic [cll_pkg::DW-1:0]        op_a, op_b, res;
	logic signed [cll_pkg::DW-1:0] px, py, sx, sy, sxy, sxx, nn;
	logic signed [cll_pkg::DW-1:0] num_sh, num_mag, t_mag, den_new;
	logic                          degen_now;

	// corners of the incoming beat
	logic signed [cll_pkg::PT_W-1:0] in_x0, in_y0, in_x1, in_y1;
	assign in_x0 = cll_pkg::PT_W'(rect.rect_left);
	assign in_y0 = cll_pkg::PT_W'(rect.rect_top);
	assign in_x1 = in_x0 + cll_pkg::PT_W'(rect.rect_width) - cll_pkg::PT_W'(1);
	assign in_y1 = in_y0 + cll_pkg::PT_W'(rect.rect_height) - cll_pkg::PT_W'(1);

	// round-to-nearest magnitude back to a saturated signed Q16.16 word
	function automatic logic [cll_pkg::OUT_W-1:0] sat_q16(input logic neg,
		input logic [cll_pkg::DW-1:0] mag);
		logic [cll_pkg::DW-1:0] lim;
		logic [cll_pkg::DW-1:0] negv;
		lim  = cll_pkg::DW'(1) << (cll_pkg::OUT_W - 1);
		negv = -mag;
		if (neg)
			sat_q16 = (mag > lim) ? lim[cll_pkg::OUT_W-1:0] : negv[cll_pkg::OUT_W-1:0];
		else
			sat_q16 = (mag > lim - 1'b1) ? cll_pkg::OUT_W'(lim - 1'b1) : mag[cll_pkg::OUT_W-1:0];
	endfunction

	// operand selection
	assign px      = cll_pkg::DW'(pt_x_q[set_q]);
	assign py      = cll_pkg::DW'(pt_y_q[set_q]);
	assign sx      = cll_pkg::DW'(sx_q[set_q]);
	assign sy      = cll_pkg::DW'(sy_q[set_q]);
	assign sxy     = cll_pkg::DW'(sxy_q[set_q]);
	assign sxx     = cll_pkg::DW'(sxx_q[set_q]);
	assign nn      = signed'(cll_pkg::DW'(count_q));
	assign num_sh  = num_q <<< cll_pkg::FRAC_W;
	assign num_mag = num_sh[cll_pkg::DW-1] ? -num_sh : num_sh;
	assign t_mag   = t_q[cll_pkg::DW-1] ? -t_q : t_q;
	assign den_new = t_q - signed'(res);
	assign degen_now = (den_new <= 0);

	always_comb begin
		op_a    = '0;
		op_b    = '0;
		unit_op = cll_pkg::OP_MUL;
		case (step_q)
			cll_pkg::A_XY:  begin op_a = px;  op_b = py;  end
			cll_pkg::A_XX:  begin op_a = px;  op_b = px;  end
			cll_pkg::F_NXY: begin op_a = nn;  op_b = sxy; end
			cll_pkg::F_SXY: begin op_a = sx;  op_b = sy;  end
			cll_pkg::F_NXX: begin op_a = nn;  op_b = sxx; end
			cll_pkg::F_SXX: begin op_a = sx;  op_b = sx;  end
			cll_pkg::F_SDIV: begin
				unit_op = cll_pkg::OP_DIV;
				op_a    = num_mag + (den_q >>> 1);
				op_b    = den_q;
			end
			cll_pkg::F_SMUL: begin op_a = cll_pkg::DW'(slope_q[set_q]); op_b = sx; end
			cll_pkg::F_IDIV: begin
				unit_op = cll_pkg::OP_DIV;
				op_a    = t_mag + (nn >>> 1);
				op_b    = nn;
			end
			default: ;
		endcase
	end

	assign cmd = '{start: unit_start, op: unit_op};

	cll_mul_div u_unit (
		.clk    (clk),
		.arst_n (arst_n),
		.cmd    (cmd),
		.a      (op_a),
		.b      (op_b),
		.sts    (sts),
		.res    (res)
	);

	// sequencer state
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= cll_pkg::S_IDLE;
			step_q  <= cll_pkg::A_XY;
			set_q   <= 1'b0;
			pend_q  <= 1'b0;
		end else begin
			state_q <= state_d;
			step_q  <= step_d;
			set_q   <= set_d;
			if (cmd.start)
				pend_q <= 1'b1;
			else if (sts.done)
				pend_q <= 1'b0;
		end
	end

	// next state and handshake outputs
	always_comb begin
		state_d    = state_q;
		step_d     = step_q;
		set_d      = set_q;
		rect.ready = 1'b0;
		unit_start = 1'b0;
		out_load   = 1'b0;
		unique case (state_q)
			cll_pkg::S_IDLE: begin
				rect.ready = 1'b1;
				if (rect.valid) begin
					set_d = 1'b0;
					if (count_q < cll_pkg::CNT_W'(cll_pkg::MAX_RECTS)) begin
						state_d = cll_pkg::S_RUN;
						step_d  = cll_pkg::A_XY;
					end else if (rect.last_rect) begin
						state_d = cll_pkg::S_RUN;
						step_d  = cll_pkg::F_NXY;
					end
				end
			end
			cll_pkg::S_RUN: begin
				unit_start = !pend_q;
				if (sts.done) begin
					case (step_q)
						cll_pkg::A_XY: step_d = cll_pkg::A_XX;
						cll_pkg::A_XX: begin
							if (!set_q) begin
								set_d  = 1'b1;
								step_d = cll_pkg::A_XY;
							end else begin
								set_d  = 1'b0;
								step_d = cll_pkg::F_NXY;
								if (!last_q)
									state_d = cll_pkg::S_IDLE;
							end
						end
						cll_pkg::F_NXY: step_d = cll_pkg::F_SXY;
						cll_pkg::F_SXY: step_d = cll_pkg::F_NXX;
						cll_pkg::F_NXX: step_d = cll_pkg::F_SXX;
						cll_pkg::F_SDIV: step_d = cll_pkg::F_SMUL;
						cll_pkg::F_SMUL: step_d = cll_pkg::F_IDIV;
						default: begin
							// end of a set: denominator was zero or intercept is done
							if (step_q == cll_pkg::F_SXX && !degen_now) begin
								step_d = cll_pkg::F_SDIV;
							end else if (!set_q) begin
								set_d  = 1'b1;
								step_d = cll_pkg::F_NXY;
							end else begin
								set_d   = 1'b0;
								state_d = cll_pkg::S_OUT;
							end
						end
					endcase
				end
			end
			cll_pkg::S_OUT: begin
				if (!out_valid_q || fit.ready) begin
					out_load = 1'b1;
					state_d  = cll_pkg::S_IDLE;
				end
			end
			default: state_d = cll_pkg::S_IDLE;
		endcase
	end

	assign rect_acc = rect.valid && rect.ready;

	// accumulators and count
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			count_q <= '0;
			for (int k = 0; k < 2; k++) begin
				sx_q[k]  <= '0;
				sy_q[k]  <= '0;
				sxy_q[k] <= '0;
				sxx_q[k] <= '0;
			end
		end else if (out_load) begin
			count_q <= '0;
			for (int k = 0; k < 2; k++) begin
				sx_q[k]  <= '0;
				sy_q[k]  <= '0;
				sxy_q[k] <= '0;
				sxx_q[k] <= '0;
			end
		end else if (state_q == cll_pkg::S_RUN && sts.done) begin
			if (step_q == cll_pkg::A_XY)
				sxy_q[set_q] <= sxy_q[set_q] + cll_pkg::SQ_W'(res);
			if (step_q == cll_pkg::A_XX) begin
				sxx_q[set_q] <= sxx_q[set_q] + cll_pkg::SQ_W'(res);
				sx_q[set_q]  <= sx_q[set_q] + cll_pkg::SUM_W'(pt_x_q[set_q]);
				sy_q[set_q]  <= sy_q[set_q] + cll_pkg::SUM_W'(pt_y_q[set_q]);
				if (set_q)
					count_q <= count_q + 1'b1;
			end
		end
	end

	// beat latch and fit datapath
	always_ff @(posedge clk) begin
		if (rect_acc) begin
			pt_x_q[0] <= in_x0;
			pt_y_q[0] <= in_y0;
			pt_x_q[1] <= in_x1;
			pt_y_q[1] <= in_y1;
			last_q    <= rect.last_rect;
		end
		if (state_q == cll_pkg::S_RUN && sts.done) begin
			case (step_q)
				cll_pkg::F_NXY, cll_pkg::F_NXX: t_q <= signed'(res);
				cll_pkg::F_SXY: num_q <= t_q - signed'(res);
				cll_pkg::F_SXX: begin
					den_q <= den_new;
					if (degen_now) begin
						degen_q[set_q] <= 1'b1;
						slope_q[set_q] <= '0;
						icpt_q[set_q]  <= '0;
					end
				end
				cll_pkg::F_SDIV: slope_q[set_q] <= signed'(sat_q16(num_q < 0, res));
				cll_pkg::F_SMUL: t_q <= (sy <<< cll_pkg::FRAC_W) - signed'(res);
				cll_pkg::F_IDIV: begin
					icpt_q[set_q]  <= signed'(sat_q16(t_q < 0, res));
					degen_q[set_q] <= 1'b0;
				end
				default: ;
			endcase
		end
	end

	// output register
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n)
			out_valid_q <= 1'b0;
		else if (out_load)
			out_valid_q <= 1'b1;
		else if (fit.ready)
			out_valid_q <= 1'b0;
	end

	always_ff @(posedge clk) begin
		if (out_load) begin
			for (int k = 0; k < 2; k++) begin
				o_slope_q[k] <= slope_q[k];
				o_icpt_q[k]  <= icpt_q[k];
				o_degen_q[k] <= degen_q[k];
			end
		end
	end

	assign fit.valid             = out_valid_q;
	assign fit.slope_top         = o_slope_q[0];
	assign fit.intercept_top     = o_icpt_q[0];
	assign fit.slope_bottom      = o_slope_q[1];
	assign fit.intercept_bottom  = o_icpt_q[1];
	assign fit.top_degenerate    = o_degen_q[0];
	assign fit.bottom_degenerate = o_degen_q[1];

	// checks
	a_start_idle: assert property (@(posedge clk) disable iff (!arst_n)
		cmd.start |-> !sts.busy && !pend_q)
		else $error("unit started while busy");

	a_ready_idle: assert property (@(posedge clk) disable iff (!arst_n)
		(state_q == cll_pkg::S_RUN) |-> !rect.ready)
		else $error("rectangle taken while sequencer runs");

	a_degen_top: assert property (@(posedge clk) disable iff (!arst_n)
		fit.valid && fit.top_degenerate |-> fit.slope_top == 0 && fit.intercept_top == 0)
		else $error("degenerate top fit with nonzero line");

	a_degen_bot: assert property (@(posedge clk) disable iff (!arst_n)
		fit.valid && fit.bottom_degenerate |->
			fit.slope_bottom == 0 && fit.intercept_bottom == 0)
		else $error("degenerate bottom fit with nonzero line");

	a_load_free: assert property (@(posedge clk) disable iff (!arst_n)
		out_load |-> !out_valid_q || fit.ready)
		else $error("result register overwritten");

endmodule
